// ===== rtl/core/spli_pkg.sv =====
// ----------------------------------------------------------------------------
// spli_pkg
// Shared constants, codes and types of the sparse pattern locate/insert block.
// ----------------------------------------------------------------------------
package spli_pkg;

  localparam int unsigned MaxRows    = 256;
  localparam int unsigned MaxCols    = 256;
  localparam int unsigned MaxEntries = 4096;

  // Field and register widths.
  localparam int unsigned DimW = 9;   // num_rows / num_cols registers
  localparam int unsigned IdxW = 9;   // signed request indices
  localparam int unsigned PosW = 12;  // result position
  localparam int unsigned StsW = 2;   // result status
  localparam int unsigned RowW = 8;   // wrapped row number
  localparam int unsigned ColW = 8;   // wrapped column number / column store word
  localparam int unsigned CntW = 13;  // entry count and row start pointers

  // Column store and row start memories.
  localparam int unsigned ColDepth = MaxEntries;
  localparam int unsigned ColAddrW = $clog2(ColDepth);
  localparam int unsigned RsDepth  = MaxRows + 1;
  localparam int unsigned RsAddrW  = $clog2(RsDepth);

  // Configuration port.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegNumRows = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegNumCols = CfgIdxW'(1);

  typedef enum logic [StsW-1:0] {
    StsFound    = 2'd0,
    StsInserted = 2'd1,
    StsRange    = 2'd2,
    StsFull     = 2'd3
  } status_e;

  typedef struct packed {
    logic                we;
    logic [ColAddrW-1:0] waddr;
    logic [ColW-1:0]     wdata;
    logic [ColAddrW-1:0] raddr;
  } col_ram_req_t;

  typedef struct packed {
    logic               we;
    logic [RsAddrW-1:0] waddr;
    logic [CntW-1:0]    wdata;
    logic [RsAddrW-1:0] raddr;
  } rs_ram_req_t;

endpackage

// ===== rtl/core/spli_if.sv =====
// ----------------------------------------------------------------------------
// spli_req_if / spli_rsp_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface spli_req_if;
  logic                               valid;
  logic                               ready;
  logic signed [spli_pkg::IdxW-1:0]   row_index;
  logic signed [spli_pkg::IdxW-1:0]   col_index;

  modport source (output valid, output row_index, output col_index, input ready);
  modport sink   (input valid, input row_index, input col_index, output ready);
endinterface

interface spli_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [spli_pkg::PosW-1:0]  position;
  logic [spli_pkg::StsW-1:0]  status;

  modport source (output valid, output position, output status, input ready);
  modport sink   (input valid, input position, input status, output ready);
endinterface

// ===== rtl/core/sparse_pattern_locate_insert.sv =====
// ----------------------------------------------------------------------------
// sparse_pattern_locate_insert
// Compressed-row sparsity pattern with locate-or-insert requests.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Beat contents
//   -------  ---  -----------------------------------------------
//   req_i    in   row_index, col_index (signed, wrapped by dimension)
//   rsp_o    out  position, status
//   cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// Reset clears the row start memory while requests wait.
// An error or a dense hit needs no memory read; a search reads the row's start and
// end pointers, then compares the row's entries in order until a hit or the row end.
// An insertion shifts later entries up one place and raises each row start behind the row.
// A waiting result holds the next request in its last step until the slot frees.
//
module sparse_pattern_locate_insert (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  spli_req_if.sink                      req_i,
  spli_rsp_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  logic [spli_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spli_pkg::DimW-1:0]     cfg_data_i
);

  spli_pkg::col_ram_req_t          col_req;
  spli_pkg::rs_ram_req_t           rs_req;
  logic [spli_pkg::ColW-1:0]       col_rdata;
  logic [spli_pkg::CntW-1:0]       rs_rdata;

  spli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .col_req_o   (col_req),
    .col_rdata_i (col_rdata),
    .rs_req_o    (rs_req),
    .rs_rdata_i  (rs_rdata)
  );

  // Column number of each stored entry.
  spli_ram #(
    .Width (spli_pkg::ColW),
    .Depth (spli_pkg::ColDepth)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_req.we),
    .waddr_i (col_req.waddr),
    .wdata_i (col_req.wdata),
    .raddr_i (col_req.raddr),
    .rdata_o (col_rdata)
  );

  // Start pointer of each row, plus the end marker.
  spli_ram #(
    .Width (spli_pkg::CntW),
    .Depth (spli_pkg::RsDepth)
  ) u_rs_ram (
    .clk_i   (clk_i),
    .we_i    (rs_req.we),
    .waddr_i (rs_req.waddr),
    .wdata_i (rs_req.wdata),
    .raddr_i (rs_req.raddr),
    .rdata_o (rs_rdata)
  );

endmodule

// ===== rtl/core/spli_ram.sv =====
// ----------------------------------------------------------------------------
// spli_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spli_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/spli_ctrl.sv =====
// ----------------------------------------------------------------------------
// spli_ctrl
// Sequencer: index wrapping, row search, column shift and row start update.
// ----------------------------------------------------------------------------
module spli_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  spli_req_if.sink                      req_i,
  spli_rsp_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  logic [spli_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spli_pkg::DimW-1:0]     cfg_data_i,
  output spli_pkg::col_ram_req_t        col_req_o,
  input  logic [spli_pkg::ColW-1:0]     col_rdata_i,
  output spli_pkg::rs_ram_req_t         rs_req_o,
  input  logic [spli_pkg::CntW-1:0]     rs_rdata_i
);

  localparam int unsigned DimW = spli_pkg::DimW;
  localparam int unsigned CntW = spli_pkg::CntW;
  localparam int unsigned CAW  = spli_pkg::ColAddrW;
  localparam int unsigned RAW  = spli_pkg::RsAddrW;
  localparam int unsigned PosW = spli_pkg::PosW;

  localparam logic [3:0] SClear = 4'd0;
  localparam logic [3:0] SIdle  = 4'd1;
  localparam logic [3:0] SLook  = 4'd2;
  localparam logic [3:0] SRs0   = 4'd3;
  localparam logic [3:0] SRs1   = 4'd4;
  localparam logic [3:0] SScan  = 4'd5;
  localparam logic [3:0] SShift = 4'd6;
  localparam logic [3:0] SLast  = 4'd7;
  localparam logic [3:0] SIns   = 4'd8;
  localparam logic [3:0] SRinc  = 4'd9;
  localparam logic [3:0] SDone  = 4'd10;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                 input logic [DimW-1:0] maxv);
    logic [DimW-1:0] u;
    u = v;
    if (u == '0) u = DimW'(1);
    if (u > maxv) u = maxv;
    return u;
  endfunction

  logic [3:0]             state_q, state_d;
  logic [DimW-1:0]        num_rows_q, num_rows_d;
  logic [DimW-1:0]        num_cols_q, num_cols_d;
  logic [CntW-1:0]        entry_count_q, entry_count_d;
  logic [RAW-1:0]         clr_q, clr_d;
  logic                   pend_q, pend_d;
  logic                   out_vld_q, out_vld_d;

  logic [spli_pkg::RowW-1:0] row_q, row_d;
  logic [spli_pkg::ColW-1:0] col_q, col_d;
  logic                      bad_q, bad_d;
  logic [CntW-1:0]           k_q, k_d;
  logic [CntW-1:0]           end_q, end_d;
  logic [CAW-1:0]            p_q, p_d;
  logic [CAW-1:0]            wa_q, wa_d;
  logic [RAW-1:0]            m_q, m_d;
  logic [PosW-1:0]           res_pos_q, res_pos_d;
  spli_pkg::status_e         res_sts_q, res_sts_d;
  logic [PosW-1:0]           out_pos_q, out_pos_d;
  spli_pkg::status_e         out_sts_q, out_sts_d;

  logic [DimW:0]   r_wrap, c_wrap;
  logic            r_ok, c_ok;
  logic [17:0]     dim_prod;
  logic [17:0]     dense_pos;
  logic            accept, out_load;

  // Wrap negative indices by adding the dimension; the sum stays in 10-bit signed range.
  always_comb begin
    r_wrap = {req_i.row_index[DimW-1], req_i.row_index}
           + (req_i.row_index[DimW-1] ? {1'b0, num_rows_q} : '0);
    c_wrap = {req_i.col_index[DimW-1], req_i.col_index}
           + (req_i.col_index[DimW-1] ? {1'b0, num_cols_q} : '0);
    r_ok   = !r_wrap[DimW] && (r_wrap[DimW-1:0] < num_rows_q);
    c_ok   = !c_wrap[DimW] && (c_wrap[DimW-1:0] < num_cols_q);
  end

  assign dim_prod  = num_rows_q * num_cols_q;
  assign dense_pos = {10'd0, col_q} + 18'(row_q * num_cols_q);

  assign req_i.ready    = (state_q == SIdle);
  assign accept         = req_i.valid && req_i.ready;
  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.position = out_pos_q;
  assign rsp_o.status   = out_sts_q;

  always_comb begin
    state_d       = state_q;
    num_rows_d    = num_rows_q;
    num_cols_d    = num_cols_q;
    entry_count_d = entry_count_q;
    clr_d         = clr_q;
    pend_d        = pend_q;
    row_d         = row_q;
    col_d         = col_q;
    bad_d         = bad_q;
    k_d           = k_q;
    end_d         = end_q;
    p_d           = p_q;
    wa_d          = wa_q;
    m_d           = m_q;
    res_pos_d     = res_pos_q;
    res_sts_d     = res_sts_q;
    out_pos_d     = out_pos_q;
    out_sts_d     = out_sts_q;
    out_load      = 1'b0;
    col_req_o     = '0;
    rs_req_o      = '0;

    // Dimensions can only change while the pattern is empty.
    if (cfg_we_i && (entry_count_q == '0)) begin
      unique case (cfg_idx_i)
        spli_pkg::RegNumRows: num_rows_d = clamp_dim(cfg_data_i, DimW'(spli_pkg::MaxRows));
        spli_pkg::RegNumCols: num_cols_d = clamp_dim(cfg_data_i, DimW'(spli_pkg::MaxCols));
        default: ;
      endcase
    end

    unique case (state_q)
      SClear: begin
        rs_req_o.we    = 1'b1;
        rs_req_o.waddr = clr_q;
        rs_req_o.wdata = '0;
        if (clr_q == RAW'(spli_pkg::RsDepth - 1)) begin
          state_d = SIdle;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      SIdle: begin
        if (accept) begin
          row_d   = r_wrap[spli_pkg::RowW-1:0];
          col_d   = c_wrap[spli_pkg::ColW-1:0];
          bad_d   = !(r_ok && c_ok);
          state_d = SLook;
        end
      end
      SLook: begin
        if (bad_q) begin
          res_pos_d = '0;
          res_sts_d = spli_pkg::StsRange;
          state_d   = SDone;
        end else if (dim_prod == {5'd0, entry_count_q}) begin
          res_pos_d = dense_pos[PosW-1:0];
          res_sts_d = spli_pkg::StsFound;
          state_d   = SDone;
        end else begin
          rs_req_o.raddr = {1'b0, row_q};
          state_d        = SRs0;
        end
      end
      SRs0: begin
        k_d            = rs_rdata_i;
        rs_req_o.raddr = {1'b0, row_q} + 1'b1;
        state_d        = SRs1;
      end
      SRs1: begin
        end_d           = (rs_rdata_i < entry_count_q) ? rs_rdata_i : entry_count_q;
        col_req_o.raddr = k_q[CAW-1:0];
        state_d         = SScan;
      end
      SScan: begin
        // The read for the next entry is issued while this one is compared.
        col_req_o.raddr = k_q[CAW-1:0] + 1'b1;
        if (k_q < end_q && col_rdata_i == col_q) begin
          res_pos_d = k_q[PosW-1:0];
          res_sts_d = spli_pkg::StsFound;
          state_d   = SDone;
        end else if (k_q < end_q && col_rdata_i < col_q) begin
          k_d = k_q + 1'b1;
        end else if (entry_count_q >= CntW'(spli_pkg::MaxEntries)) begin
          res_pos_d = '0;
          res_sts_d = spli_pkg::StsFull;
          state_d   = SDone;
        end else if (entry_count_q == k_q) begin
          state_d = SIns;
        end else begin
          p_d     = CAW'(entry_count_q - 1'b1);
          pend_d  = 1'b0;
          state_d = SShift;
        end
      end
      SShift: begin
        // Read entry p while the entry read at p + 1 is written one place up, at p + 2.
        col_req_o.raddr = p_q;
        col_req_o.we    = pend_q;
        col_req_o.waddr = wa_q;
        col_req_o.wdata = col_rdata_i;
        wa_d            = p_q + 1'b1;
        pend_d          = 1'b1;
        if (p_q == k_q[CAW-1:0]) begin
          state_d = SLast;
        end else begin
          p_d = p_q - 1'b1;
        end
      end
      SLast: begin
        col_req_o.we    = 1'b1;
        col_req_o.waddr = wa_q;
        col_req_o.wdata = col_rdata_i;
        state_d         = SIns;
      end
      SIns: begin
        col_req_o.we    = 1'b1;
        col_req_o.waddr = k_q[CAW-1:0];
        col_req_o.wdata = col_q;
        entry_count_d   = entry_count_q + 1'b1;
        rs_req_o.raddr  = {1'b0, row_q} + 1'b1;
        m_d             = {1'b0, row_q} + 1'b1;
        state_d         = SRinc;
      end
      SRinc: begin
        rs_req_o.we    = 1'b1;
        rs_req_o.waddr = m_q;
        rs_req_o.wdata = CntW'(rs_rdata_i + 1'b1);
        if (m_q == num_rows_q) begin
          res_pos_d = k_q[PosW-1:0];
          res_sts_d = spli_pkg::StsInserted;
          state_d   = SDone;
        end else begin
          rs_req_o.raddr = m_q + 1'b1;
          m_d            = m_q + 1'b1;
        end
      end
      SDone: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_load  = 1'b1;
          out_pos_d = res_pos_q;
          out_sts_d = res_sts_q;
          state_d   = SIdle;
        end
      end
      default: state_d = SClear;
    endcase

    out_vld_d = out_load || (out_vld_q && !rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SClear;
      num_rows_q    <= DimW'(1);
      num_cols_q    <= DimW'(1);
      entry_count_q <= '0;
      clr_q         <= '0;
      pend_q        <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      num_rows_q    <= num_rows_d;
      num_cols_q    <= num_cols_d;
      entry_count_q <= entry_count_d;
      clr_q         <= clr_d;
      pend_q        <= pend_d;
      out_vld_q     <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q     <= row_d;
    col_q     <= col_d;
    bad_q     <= bad_d;
    k_q       <= k_d;
    end_q     <= end_d;
    p_q       <= p_d;
    wa_q      <= wa_d;
    m_q       <= m_d;
    res_pos_q <= res_pos_d;
    res_sts_q <= res_sts_d;
    out_pos_q <= out_pos_d;
    out_sts_q <= out_sts_d;
  end

endmodule

// ===== rtl/core/spli_checker.sv =====
// ----------------------------------------------------------------------------
// spli_checker
// Port-level checks of the locate/insert block, bound to the top level.
// ----------------------------------------------------------------------------
module spli_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [spli_pkg::PosW-1:0]  rsp_position_i,
  input logic [spli_pkg::StsW-1:0]  rsp_status_i
);

  logic [1:0] pending_q;
  logic       req_beat, rsp_beat;

  assign req_beat = req_valid_i && req_ready_i;
  assign rsp_beat = rsp_valid_i && rsp_ready_i;

  // Requests taken but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {1'b0, req_beat} - {1'b0, rsp_beat};
    end
  end

  // The block holds at most one request in work and one result waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pending_q <= 2'd2)
    else $error("more than two requests outstanding");

  // A result beat always answers an earlier request.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rsp_valid_i |-> pending_q != 2'd0)
    else $error("result without a pending request");

  // Error results carry a zero position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == spli_pkg::StsRange || rsp_status_i == spli_pkg::StsFull)
    |-> rsp_position_i == '0)
    else $error("error result with nonzero position");

  // The row start memory is being cleared right after reset.
  assert property (@(posedge clk_i) !rst_ni |=> !req_ready_i)
    else $error("request taken during the clearing pass");

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_position_i)
    && $stable(rsp_status_i))
    else $error("stalled result changed");

endmodule

bind sparse_pattern_locate_insert spli_checker u_spli_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_position_i (rsp_o.position),
  .rsp_status_i   (rsp_o.status)
);
